FILE: sv/pwv_pkg.sv
// Package for the pulse waveform source: widths, register indexes, shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pwv_pkg;

    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 32;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 5;
    localparam int REG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [REG_IDX_W-1:0] REG_INITIAL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PULSE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RISE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FALL    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD  = 3'd6;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] initial_level;
        logic signed [LEVEL_W-1:0] pulse_level;
        logic [TIME_W-1:0]         delay_time;
        logic [TIME_W-1:0]         rise_time;
        logic [TIME_W-1:0]         width_time;
        logic [TIME_W-1:0]         fall_time;
        logic [TIME_W-1:0]         period_time;
    } cfg_t;

    // Classified time point passed from the front part to the back part.
    typedef struct packed {
        logic              pre_delay;
        logic [TIME_W-1:0] phase;
    } item_t;

endpackage

FILE: sv/pulse_waveform_value.sv
// Top level of the periodic trapezoid pulse source: register file and the
// front part, queue and back part. Depends on pwv_pkg, pwv_front, pwv_queue, pwv_back.
`timescale 1ns / 1ps

//  Channel   Ports                                   Transfer when
//  ------    ------------------------------------    ---------------------------
//  input     time_point, push, full                  push && !full
//  result    level, empty, pop                       pop && !empty
//  config    psel penable pwrite paddr pwdata        psel && penable && pwrite
//            prdata pready                           (pready tied high)
//
//  One time point enters per clock while full is low and one level leaves
//  per clock while pop is held. A time point passes the front part (one
//  modulo step per stage), the queue, then the back part (three segment
//  stages, a multiply, one division step per stage, and the output register).
//  Reset clears all valid bits and loads the registers with their defaults
//  (period one, all else zero). A stall on pop freezes the back part; the
//  front part keeps running until the four-entry queue fills and its last
//  stage holds a time point, then full rises.

module pulse_waveform_value (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               push,
    output logic                               full,
    input  logic [pwv_pkg::TIME_W-1:0]         time_point,
    // result channel
    output logic                               empty,
    input  logic                               pop,
    output logic signed [pwv_pkg::LEVEL_W-1:0] level,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pwv_pkg::PADDR_W-1:0]        paddr,
    input  logic [pwv_pkg::DATA_W-1:0]         pwdata,
    output logic [pwv_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int TW = pwv_pkg::TIME_W;
    localparam int LW = pwv_pkg::LEVEL_W;
    localparam int IW = pwv_pkg::REG_IDX_W;

    pwv_pkg::cfg_t  cfg_reg;
    logic [IW-1:0]  reg_idx;
    logic           wr_en;

    pwv_pkg::item_t q_wdata, q_rdata;
    logic           q_push, q_full, q_pop, q_empty;

    // Registers sit on 32-bit word addresses.
    assign reg_idx = paddr[IW+1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    // Write decode; an address past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_level <= '0;
            cfg_reg.pulse_level   <= '0;
            cfg_reg.delay_time    <= '0;
            cfg_reg.rise_time     <= '0;
            cfg_reg.width_time    <= '0;
            cfg_reg.fall_time     <= '0;
            cfg_reg.period_time   <= TW'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                pwv_pkg::REG_INITIAL: cfg_reg.initial_level <= pwdata[LW-1:0];
                pwv_pkg::REG_PULSE:   cfg_reg.pulse_level   <= pwdata[LW-1:0];
                pwv_pkg::REG_DELAY:   cfg_reg.delay_time    <= pwdata[TW-1:0];
                pwv_pkg::REG_RISE:    cfg_reg.rise_time     <= pwdata[TW-1:0];
                pwv_pkg::REG_WIDTH:   cfg_reg.width_time    <= pwdata[TW-1:0];
                pwv_pkg::REG_FALL:    cfg_reg.fall_time     <= pwdata[TW-1:0];
                pwv_pkg::REG_PERIOD:  cfg_reg.period_time   <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            pwv_pkg::REG_INITIAL: prdata = cfg_reg.initial_level;
            pwv_pkg::REG_PULSE:   prdata = cfg_reg.pulse_level;
            pwv_pkg::REG_DELAY:   prdata = cfg_reg.delay_time;
            pwv_pkg::REG_RISE:    prdata = cfg_reg.rise_time;
            pwv_pkg::REG_WIDTH:   prdata = cfg_reg.width_time;
            pwv_pkg::REG_FALL:    prdata = cfg_reg.fall_time;
            pwv_pkg::REG_PERIOD:  prdata = cfg_reg.period_time;
            default:              prdata = '0;
        endcase
    end

    // Front: delay split and phase reduction
    pwv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .push       (push),
        .time_point (time_point),
        .full       (full),
        .q_push     (q_push),
        .q_wdata    (q_wdata),
        .q_full     (q_full)
    );

    // Decouple front and back stalls
    pwv_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back: segment select, ramp scaling, result register
    pwv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_rdata (q_rdata),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .level   (level),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

FILE: sv/pwv_queue.sv
// Short flop-based queue between the front and back parts.
// Depends on pwv_pkg (item_t, QUEUE_DEPTH, QPTR_W).
`timescale 1ns / 1ps

module pwv_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pwv_pkg::item_t wdata,
    output logic           full,
    input  logic           pop,
    output pwv_pkg::item_t rdata,
    output logic           empty
);

    localparam int PW = pwv_pkg::QPTR_W;

    pwv_pkg::item_t    mem_reg [0:pwv_pkg::QUEUE_DEPTH-1];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       count_reg;
    logic [PW:0]       count_next;

    assign full  = (count_reg == (PW+1)'(pwv_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(pwv_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

FILE: sv/pwv_front.sv
// Front part: take time points, split off the delay, reduce modulo the period.
// Depends on pwv_pkg; one restoring-division step per stage.
`timescale 1ns / 1ps

module pwv_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pwv_pkg::cfg_t               cfg,
    input  logic                        push,
    input  logic [pwv_pkg::TIME_W-1:0]  time_point,
    output logic                        full,
    output logic                        q_push,
    output pwv_pkg::item_t              q_wdata,
    input  logic                        q_full
);

    localparam int TW = pwv_pkg::TIME_W;

    logic          valid_reg  [0:TW];
    logic          before_reg [0:TW];
    logic [TW-1:0] x_reg      [0:TW];
    logic [TW:0]   rem_reg    [0:TW];
    logic [TW:0]   rem_next   [1:TW];
    logic          en;

    // Stall the whole chain only when its last stage cannot move into the queue.
    assign en     = !valid_reg[TW] || !q_full;
    assign full   = !en;
    assign q_push = valid_reg[TW] && !q_full;

    always_comb
    begin
        q_wdata.pre_delay = before_reg[TW];
        q_wdata.phase     = (cfg.period_time == '0) ? x_reg[TW] : rem_reg[TW][TW-1:0];
    end

    always_comb
    begin
        logic [TW:0] sh;
        for (int k = 1; k <= TW; k++)
        begin
            sh = {rem_reg[k-1][TW-1:0], x_reg[k-1][TW-k]};
            if (sh >= {1'b0, cfg.period_time})
            begin
                rem_next[k] = sh - {1'b0, cfg.period_time};
            end
            else
            begin
                rem_next[k] = sh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= TW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= push;
            for (int k = 1; k <= TW; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            before_reg[0] <= (time_point <= cfg.delay_time);
            x_reg[0]      <= time_point - cfg.delay_time;
            rem_reg[0]    <= '0;
            for (int k = 1; k <= TW; k++)
            begin
                before_reg[k] <= before_reg[k-1];
                x_reg[k]      <= x_reg[k-1];
                rem_reg[k]    <= rem_next[k];
            end
        end
    end

endmodule

FILE: sv/pwv_back.sv
// Back part: locate the phase in the pulse, scale the ramp, hold the result.
// Depends on pwv_pkg; one multiply stage, then one division step per stage.
`timescale 1ns / 1ps

module pwv_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pwv_pkg::cfg_t                      cfg,
    input  pwv_pkg::item_t                     q_rdata,
    input  logic                               q_empty,
    output logic                               q_pop,
    output logic signed [pwv_pkg::LEVEL_W-1:0] level,
    output logic                               empty,
    input  logic                               pop
);

    localparam int TW = pwv_pkg::TIME_W;
    localparam int LW = pwv_pkg::LEVEL_W;

    logic en;

    // Segment stages
    logic          s1_valid_reg, s1_before_reg, s1_lt_rise_reg;
    logic [TW-1:0] s1_phase_reg, s1_rest_reg;
    logic          s2_valid_reg, s2_before_reg, s2_lt_rise_reg, s2_lt_width_reg;
    logic [TW-1:0] s2_phase_reg, s2_rest_reg;

    // Ramp setup
    logic          s3_valid_reg, s3_ramp_reg, s3_neg_reg;
    logic [LW-1:0] s3_from_reg, s3_mag_reg;
    logic [TW-1:0] s3_el_reg, s3_len_reg;
    logic          s3_ramp_next, s3_neg_next;
    logic [LW-1:0] s3_from_next, s3_mag_next;
    logic [TW-1:0] s3_el_next, s3_len_next;

    // Division chain; stage 0 holds the product
    logic          d_valid_reg [0:LW];
    logic          d_ramp_reg  [0:LW];
    logic          d_neg_reg   [0:LW];
    logic [LW-1:0] d_from_reg  [0:LW];
    logic [TW-1:0] d_len_reg   [0:LW];
    logic [LW-1:0] d_lo_reg    [0:LW];
    logic [TW:0]   d_rem_reg   [0:LW];
    logic [LW-1:0] d_quo_reg   [0:LW];
    logic [TW:0]   d_rem_next  [1:LW];
    logic [LW-1:0] d_quo_next  [1:LW];
    logic [LW+TW-1:0] prod;

    logic          out_valid_reg;
    logic [LW-1:0] level_reg, level_next;

    logic signed [LW:0] up_diff;
    logic               up_neg;
    logic [LW:0]        up_abs;
    logic [LW-1:0]      q_eff;

    assign en    = !out_valid_reg || pop;
    assign q_pop = en && !q_empty;
    assign empty = !out_valid_reg;
    assign level = level_reg;

    assign up_diff = $signed({cfg.pulse_level[LW-1], cfg.pulse_level})
                   - $signed({cfg.initial_level[LW-1], cfg.initial_level});
    assign up_neg  = up_diff[LW];
    assign up_abs  = up_neg ? -up_diff : up_diff;

    always_comb
    begin
        s3_ramp_next = 1'b0;
        s3_neg_next  = 1'b0;
        s3_from_next = cfg.initial_level;
        s3_mag_next  = up_abs[LW-1:0];
        s3_el_next   = '0;
        s3_len_next  = cfg.rise_time;
        priority if (s2_before_reg)
        begin
            s3_from_next = cfg.initial_level;
        end
        else if (s2_lt_rise_reg)
        begin
            s3_ramp_next = 1'b1;
            s3_neg_next  = up_neg;
            s3_el_next   = s2_phase_reg;
            s3_len_next  = cfg.rise_time;
        end
        else if (s2_lt_width_reg)
        begin
            s3_from_next = cfg.pulse_level;
        end
        else if (s2_rest_reg < cfg.fall_time)
        begin
            s3_ramp_next = 1'b1;
            s3_neg_next  = !up_neg;
            s3_from_next = cfg.pulse_level;
            s3_el_next   = s2_rest_reg;
            s3_len_next  = cfg.fall_time;
        end
        else
        begin
            s3_from_next = cfg.initial_level;
        end
    end

    assign prod = {{TW{1'b0}}, s3_mag_reg} * {{LW{1'b0}}, s3_el_reg};

    // Quotient fits in LW bits, so the top TW product bits start as remainder.
    always_comb
    begin
        logic [TW:0] sh;
        for (int k = 1; k <= LW; k++)
        begin
            sh = {d_rem_reg[k-1][TW-1:0], d_lo_reg[k-1][LW-k]};
            if (sh >= {1'b0, d_len_reg[k-1]})
            begin
                d_rem_next[k] = sh - {1'b0, d_len_reg[k-1]};
                d_quo_next[k] = {d_quo_reg[k-1][LW-2:0], 1'b1};
            end
            else
            begin
                d_rem_next[k] = sh;
                d_quo_next[k] = {d_quo_reg[k-1][LW-2:0], 1'b0};
            end
        end
    end

    assign q_eff      = d_ramp_reg[LW] ? d_quo_reg[LW] : '0;
    assign level_next = d_neg_reg[LW] ? d_from_reg[LW] - q_eff : d_from_reg[LW] + q_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= LW; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg   <= !q_empty;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            d_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k <= LW; k++)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
            out_valid_reg <= d_valid_reg[LW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_before_reg   <= q_rdata.pre_delay;
            s1_phase_reg    <= q_rdata.phase;
            s1_lt_rise_reg  <= q_rdata.phase < cfg.rise_time;
            s1_rest_reg     <= q_rdata.phase - cfg.rise_time;

            s2_before_reg   <= s1_before_reg;
            s2_phase_reg    <= s1_phase_reg;
            s2_lt_rise_reg  <= s1_lt_rise_reg;
            s2_lt_width_reg <= s1_rest_reg < cfg.width_time;
            s2_rest_reg     <= s1_rest_reg - cfg.width_time;

            s3_ramp_reg <= s3_ramp_next;
            s3_neg_reg  <= s3_neg_next;
            s3_from_reg <= s3_from_next;
            s3_mag_reg  <= s3_mag_next;
            s3_el_reg   <= s3_el_next;
            s3_len_reg  <= s3_len_next;

            d_ramp_reg[0] <= s3_ramp_reg;
            d_neg_reg[0]  <= s3_neg_reg;
            d_from_reg[0] <= s3_from_reg;
            d_len_reg[0]  <= s3_len_reg;
            d_lo_reg[0]   <= prod[LW-1:0];
            d_rem_reg[0]  <= {1'b0, prod[LW+TW-1:LW]};
            d_quo_reg[0]  <= '0;
            for (int k = 1; k <= LW; k++)
            begin
                d_ramp_reg[k] <= d_ramp_reg[k-1];
                d_neg_reg[k]  <= d_neg_reg[k-1];
                d_from_reg[k] <= d_from_reg[k-1];
                d_len_reg[k]  <= d_len_reg[k-1];
                d_lo_reg[k]   <= d_lo_reg[k-1];
                d_rem_reg[k]  <= d_rem_next[k];
                d_quo_reg[k]  <= d_quo_next[k];
            end

            level_reg <= level_next;
        end
    end

endmodule
